/* hw/rtl/mado_pkg.sv */
package mado_pkg;

  localparam int ADC_FULL   = 4095;
  localparam int SAMPLE_W   = 12;
  localparam int CH_IN_W    = 3;
  localparam int OHMS_W     = 20;
  localparam int SUPPLY_W   = 13;
  localparam int RES_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [OHMS_W-1:0]   FIXED_OHMS_RST = 20'd10000;
  localparam logic [SUPPLY_W-1:0] SUPPLY_MV_RST  = 13'd3300;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIXED_OHMS = 1'b0,
    REG_SUPPLY_MV  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ACT_PRIME   = 1'b0,
    ACT_MEASURE = 1'b1
  } action_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // bits needed for a full window sum
  function automatic int sum_width(input int window);
    return $clog2(ADC_FULL * window + 1);
  endfunction

endpackage

/* hw/rtl/mado_ram.sv */
module mado_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mado_queue.sv */
module mado_queue #(
  parameter int W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [W-1:0]        pdata_i,
  input  logic                pop_i,
  output logic [W-1:0]        head_o,
  output mado_pkg::q_status_t status_o
);
  import mado_pkg::*;

  logic [W-1:0]    mem_q [Q_DEPTH];
  logic [Q_PW-1:0] wptr_q, rptr_q;
  logic [Q_CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= Q_PW'(wptr_q + 1'b1);
      end
      if (pop_i) begin
        rptr_q <= Q_PW'(rptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= Q_CW'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= Q_CW'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= pdata_i;
    end
  end

  always_comb begin
    head_o         = mem_q[rptr_q];
    status_o.full  = (cnt_q == Q_CW'(Q_DEPTH));
    status_o.empty = (cnt_q == '0);
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CW'(Q_DEPTH)) else $error("queue count out of range");

endmodule

/* hw/rtl/mado_front.sv */
module mado_front #(
  parameter int CHANNELS = 8,
  parameter int WINDOW = 16,
  localparam int SUM_W = mado_pkg::sum_width(WINDOW),
  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int ENT_W = CH_AW + SUM_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [mado_pkg::CH_IN_W-1:0]   channel_i,
  input  logic [mado_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                           push_o,
  output logic [ENT_W-1:0]               push_data_o,
  input  mado_pkg::q_status_t            q_status_i
);
  import mado_pkg::*;

  localparam int SL_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SA_W = (CHANNELS * WINDOW > 1) ? $clog2(CHANNELS * WINDOW) : 1;
  localparam int CS_W = 1 + SL_W + SUM_W;

  typedef struct packed {
    logic             wrapped;
    logic [SL_W-1:0]  slot;
    logic [SUM_W-1:0] sum;
  } ch_state_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RD,
    F_UPD
  } fstate_e;

  fstate_e              state_q, state_d;
  logic [CHANNELS-1:0]  ch_vld_q;
  action_e              act_q;
  logic [CH_AW-1:0]     ch_q;
  logic [SAMPLE_W-1:0]  smp_q;
  logic [SL_W-1:0]      slot_q;
  logic                 wrap_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SA_W-1:0]      sa_q, sa_d;

  logic                 accept, upd_go, last;
  logic [CS_W-1:0]      cs_raw;
  ch_state_t            cs_rd, cs_wdata;
  logic [SAMPLE_W-1:0]  s_rdata, old_smp;
  logic [SUM_W-1:0]     new_sum;

  always_comb begin
    in_stall_o = (state_q != F_IDLE);
    accept     = in_valid_i && (state_q == F_IDLE) && (int'(channel_i) < CHANNELS);
    // an entry never written reads as the reset value
    cs_rd      = ch_vld_q[ch_q] ? ch_state_t'(cs_raw) : '0;
    sa_d       = SA_W'(SA_W'(ch_q) * SA_W'(WINDOW) + SA_W'(cs_rd.slot));
    // before the first wrap the slot being replaced still holds zero
    old_smp    = wrap_q ? s_rdata : '0;
    new_sum    = SUM_W'(sum_q - SUM_W'(old_smp) + SUM_W'(smp_q));
    last       = (slot_q == SL_W'(WINDOW - 1));
    upd_go     = (state_q == F_UPD) && ((act_q != ACT_MEASURE) || !q_status_i.full);
    cs_wdata.wrapped = wrap_q | last;
    cs_wdata.slot    = last ? '0 : SL_W'(slot_q + 1'b1);
    cs_wdata.sum     = new_sum;
    push_o      = upd_go && (act_q == ACT_MEASURE);
    push_data_o = {ch_q, new_sum};

    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_RD;
        end
      end
      F_RD: state_d = F_UPD;
      F_UPD: begin
        if (upd_go) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      ch_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (upd_go) begin
        ch_vld_q[ch_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_e'(action_i);
      ch_q  <= CH_AW'(channel_i);
      smp_q <= sample_i;
    end
    if (state_q == F_RD) begin
      slot_q <= cs_rd.slot;
      wrap_q <= cs_rd.wrapped;
      sum_q  <= cs_rd.sum;
      sa_q   <= sa_d;
    end
  end

  mado_ram #(
    .WIDTH(CS_W),
    .DEPTH(CHANNELS)
  ) u_ch_ram (
    .clk_i  (clk_i),
    .we_i   (upd_go),
    .waddr_i(ch_q),
    .wdata_i(cs_wdata),
    .re_i   (accept),
    .raddr_i(CH_AW'(channel_i)),
    .rdata_o(cs_raw)
  );

  mado_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(CHANNELS * WINDOW)
  ) u_smp_ram (
    .clk_i  (clk_i),
    .we_i   (upd_go),
    .waddr_i(sa_q),
    .wdata_i(smp_q),
    .re_i   (state_q == F_RD),
    .raddr_i(sa_d),
    .rdata_o(s_rdata)
  );

endmodule

/* hw/rtl/mado_back.sv */
module mado_back #(
  parameter int CHANNELS = 8,
  parameter int WINDOW = 16,
  localparam int SUM_W = mado_pkg::sum_width(WINDOW),
  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int ENT_W = CH_AW + SUM_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ENT_W-1:0]               head_i,
  input  mado_pkg::q_status_t            q_status_i,
  output logic                           pop_o,
  input  logic [mado_pkg::OHMS_W-1:0]    fixed_ohms_i,
  input  logic [mado_pkg::SUPPLY_W-1:0]  supply_mv_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mado_pkg::CH_IN_W-1:0]   out_channel_o,
  output logic [mado_pkg::RES_W-1:0]     resistance_ohms_o,
  output logic                           open_circuit_o,
  output logic                           saturated_o
);
  import mado_pkg::*;

  localparam int FULL_SUM = ADC_FULL * WINDOW;
  localparam int PROD_W   = SUPPLY_W + SUM_W;
  localparam int NUM_W    = OHMS_W + SUM_W;
  localparam int NUMX_W   = (NUM_W > RES_W) ? NUM_W : RES_W + 1;
  localparam int HI_W     = (NUMX_W - RES_W > SUM_W) ? NUMX_W - RES_W : SUM_W;
  localparam int CNT_W    = $clog2(RES_W);

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_CHK,
    B_DIV,
    B_OUT
  } bstate_e;

  bstate_e            state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CH_AW-1:0]   ch_q;
  logic [SUM_W-1:0]   sum_q;
  logic               open_q, sat_q;
  logic [NUMX_W-1:0]  num_q;
  logic [SUM_W-1:0]   rem_q;
  logic [RES_W-1:0]   quo_q;

  logic [PROD_W-1:0]  prod;
  logic               is_open, too_big, ge;
  logic [NUMX_W-1:0]  num;
  logic [HI_W-1:0]    hi;
  logic [SUM_W:0]     trial, diff;

  always_comb begin
    pop_o   = (state_q == B_IDLE) && !q_status_i.empty;
    prod    = PROD_W'(supply_mv_i) * PROD_W'(sum_q);
    is_open = prod < PROD_W'(FULL_SUM);
    num     = NUMX_W'(fixed_ohms_i) * NUMX_W'(SUM_W'(FULL_SUM) - sum_q);
    // quotient overflows exactly when the bits above the result reach the divisor
    hi      = HI_W'(num_q[NUMX_W-1:RES_W]);
    too_big = hi >= HI_W'(sum_q);
    trial   = {rem_q, quo_q[RES_W-1]};
    ge      = trial >= {1'b0, sum_q};
    diff    = trial - {1'b0, sum_q};

    out_valid_o       = (state_q == B_OUT);
    out_channel_o     = CH_IN_W'(ch_q);
    resistance_ohms_o = quo_q;
    open_circuit_o    = open_q;
    saturated_o       = sat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            state_q <= B_MUL;
          end
        end
        B_MUL: state_q <= B_CHK;
        B_CHK: begin
          cnt_q <= '0;
          if (open_q || too_big) begin
            state_q <= B_OUT;
          end else begin
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          cnt_q <= CNT_W'(cnt_q + 1'b1);
          if (cnt_q == CNT_W'(RES_W - 1)) begin
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_stall_i) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          ch_q  <= head_i[ENT_W-1:SUM_W];
          sum_q <= head_i[SUM_W-1:0];
        end
      end
      B_MUL: begin
        open_q <= is_open;
        num_q  <= num;
      end
      B_CHK: begin
        if (open_q || too_big) begin
          quo_q <= '1;
          sat_q <= 1'b1;
        end else begin
          rem_q <= SUM_W'(hi);
          quo_q <= num_q[RES_W-1:0];
          sat_q <= 1'b0;
        end
      end
      B_DIV: begin
        // restoring step: shift in one dividend bit, subtract if it fits
        rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        quo_q <= {quo_q[RES_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  a_open_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && open_circuit_o |-> saturated_o && (&resistance_ohms_o))
    else $error("open circuit result not clamped");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> rem_q < sum_q)
    else $error("division remainder escaped divisor");
  a_plain_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !saturated_o |-> $past(state_q) == B_DIV)
    else $error("unclamped result without division");

endmodule

/* hw/rtl/multichannel_average_divider_ohms.sv */
// Moving-average divider resistance meter.
// Input channel (in_valid_i / in_stall_o): action, channel, sample. Every
// transfer with a channel in range replaces the oldest sample of that
// channel's ring and updates its running sum; a prime item stops there, a
// measure item also yields one result. Channels out of range are dropped.
// Output channel (out_valid_o / out_stall_i): channel, resistance
// fixed_ohms*(4095*WINDOW-sum)/sum in ohms, open-circuit and saturation flags.
// The front handles each item as a channel state read, a ring read and a ring
// write, and takes no new item before that write; a queue of two measure
// entries sits before the back end. The back end runs setup (pop, multiply,
// check) and a 32-step restoring divider, one quotient bit per cycle, and pops
// no new entry until its result is taken; clamped results skip the divider.
// Config writes (cfg_we_i) must go in only while idle; the block does not
// enforce it. Reset clears all control state at once: each channel carries a
// valid bit and a wrap flag, so unwritten ring slots read as zero and no
// clearing pass is run. A stalled result holds in the output register while
// the front keeps taking items until the queue fills; then in_stall_o stays high.
module multichannel_average_divider_ohms #(
  parameter int CHANNELS = 8,
  parameter int WINDOW = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mado_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mado_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [mado_pkg::CH_IN_W-1:0]     channel_i,
  input  logic [mado_pkg::SAMPLE_W-1:0]    sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mado_pkg::CH_IN_W-1:0]     out_channel_o,
  output logic [mado_pkg::RES_W-1:0]       resistance_ohms_o,
  output logic                             open_circuit_o,
  output logic                             saturated_o
);
  import mado_pkg::*;

  localparam int SUM_W = sum_width(WINDOW);
  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENT_W = CH_AW + SUM_W;

  logic [OHMS_W-1:0]   fixed_ohms_q;
  logic [SUPPLY_W-1:0] supply_mv_q;
  logic                push, pop;
  logic [ENT_W-1:0]    push_data, head;
  q_status_t           q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_ohms_q <= FIXED_OHMS_RST;
      supply_mv_q  <= SUPPLY_MV_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FIXED_OHMS: fixed_ohms_q <= cfg_wdata_i[OHMS_W-1:0];
        REG_SUPPLY_MV:  supply_mv_q  <= cfg_wdata_i[SUPPLY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mado_front #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .channel_i  (channel_i),
    .sample_i   (sample_i),
    .push_o     (push),
    .push_data_o(push_data),
    .q_status_i (q_status)
  );

  mado_queue #(
    .W(ENT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pdata_i (push_data),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(q_status)
  );

  mado_back #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .q_status_i       (q_status),
    .pop_o            (pop),
    .fixed_ohms_i     (fixed_ohms_q),
    .supply_mv_i      (supply_mv_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_channel_o    (out_channel_o),
    .resistance_ohms_o(resistance_ohms_o),
    .open_circuit_o   (open_circuit_o),
    .saturated_o      (saturated_o)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mado_pkg::*;

  localparam int CH_N = 8;
  localparam int WIN_N = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [63:0] FULL_SCALE_SUM = 64'(ADC_FULL) * 64'(WIN_N);
  localparam logic [63:0] OHMS_CLAMP = 64'hFFFF_FFFF;

  typedef struct {
    action_e               act;
    logic [CH_IN_W-1:0]    ch;
    logic [SAMPLE_W-1:0]   sample;
    int unsigned           gap;
  } adc_item_t;

  typedef struct {
    logic [CH_IN_W-1:0] ch;
    logic [RES_W-1:0]   ohms;
    logic               open_circuit;
    logic               saturated;
  } ohm_reading_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  action_i = 1'b0;
  logic [CH_IN_W-1:0]    channel_i = '0;
  logic [SAMPLE_W-1:0]   sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CH_IN_W-1:0]    out_channel_o;
  logic [RES_W-1:0]      resistance_ohms_o;
  logic                  open_circuit_o;
  logic                  saturated_o;

  // predictor state
  logic [SAMPLE_W-1:0] ring_mem [CH_N*WIN_N] = '{default: '0};
  logic [19:0]         sum_mem [CH_N] = '{default: '0};
  logic [7:0]          slot_mem [CH_N] = '{default: '0};
  logic [OHMS_W-1:0]   ohms_cfg = FIXED_OHMS_RST;
  logic [SUPPLY_W-1:0] supply_cfg = SUPPLY_MV_RST;

  adc_item_t    adc_q[$];
  adc_item_t    tx_item;
  ohm_reading_t expected_ohms_q[$];
  ohm_reading_t exp_r;
  int unsigned  err_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  rx_wait = 0;
  int unsigned  rx_calm_left = 0;
  bit           rx_calm = 1'b0;

  multichannel_average_divider_ohms #(
    .CHANNELS(CH_N),
    .WINDOW(WIN_N)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .action_i(action_i),
    .channel_i(channel_i),
    .sample_i(sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_channel_o(out_channel_o),
    .resistance_ohms_o(resistance_ohms_o),
    .open_circuit_o(open_circuit_o),
    .saturated_o(saturated_o)
  );

  always #10 clk_i = ~clk_i;

  // Replace the oldest sample of the channel; a measure yields one reading.
  function automatic void track_sample(input action_e act, input logic [CH_IN_W-1:0] ch,
                                       input logic [SAMPLE_W-1:0] x);
    int unsigned  slot;
    int unsigned  pos;
    logic [63:0]  s;
    logic [63:0]  q;
    ohm_reading_t r;
    slot = slot_mem[ch] % WIN_N;
    pos = ch * WIN_N + slot;
    sum_mem[ch] = sum_mem[ch] - 20'(ring_mem[pos]) + 20'(x);
    ring_mem[pos] = x;
    slot_mem[ch] = 8'((slot + 1) % WIN_N);
    if (act == ACT_MEASURE) begin
      s = 64'(sum_mem[ch]);
      r.ch = ch;
      r.open_circuit = 1'b0;
      r.saturated = 1'b0;
      if (64'(supply_cfg) * s < FULL_SCALE_SUM) begin
        // covers an empty window too, so no divide by zero
        r.open_circuit = 1'b1;
        r.saturated = 1'b1;
        r.ohms = '1;
      end else begin
        q = (64'(ohms_cfg) * (FULL_SCALE_SUM - s)) / s;
        if (q > OHMS_CLAMP) begin
          q = OHMS_CLAMP;
          r.saturated = 1'b1;
        end
        r.ohms = q[RES_W-1:0];
      end
      expected_ohms_q.push_back(r);
    end
  endfunction

  function automatic int unsigned draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(input int unsigned mode);
    case (mode)
      1: return 12'd4095;
      2: return 12'($urandom_range(0, 15));
      3: return 12'd0;
      4: return 12'($urandom_range(4000, 4095));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic push_item(input action_e act, input int unsigned ch,
                           input int unsigned x, input bit calm);
    adc_item_t it;
    it.act = act;
    it.ch = CH_IN_W'(ch);
    it.sample = SAMPLE_W'(x);
    it.gap = draw_gap(calm);
    adc_q.push_back(it);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FIXED_OHMS: ohms_cfg = val[OHMS_W-1:0];
      REG_SUPPLY_MV:  supply_cfg = val[SUPPLY_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every item is in and every reading is out, then let a prime
  // still in the pipe settle.
  task automatic wait_drained();
    @(negedge clk_i);
    while (adc_q.size() != 0 || in_valid_i || expected_ohms_q.size() != 0)
      @(negedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Bursts on one channel with one sample flavor drive the window to its corners.
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned made;
    int unsigned ch;
    int unsigned mode;
    int unsigned len;
    int unsigned pct;
    bit          calm;
    made = 0;
    while (made < n_items) begin
      ch = $urandom_range(0, CH_N - 1);
      mode = $urandom_range(0, 5);
      len = $urandom_range(1, 20);
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0: pct = 15;
        1: pct = 50;
        default: pct = 90;
      endcase
      for (int k = 0; k < len; k++) begin
        push_item(($urandom_range(0, 99) < pct) ? ACT_MEASURE : ACT_PRIME,
                  ch, draw_sample(mode), calm);
      end
      made += len;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_sample(action_e'(action_i), channel_i, sample_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (adc_q.size() != 0 && adc_q[0].gap == 0) begin
          tx_item = adc_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= tx_item.act;
          channel_i <= tx_item.ch;
          sample_i <= tx_item.sample;
        end else begin
          if (adc_q.size() != 0) adc_q[0].gap = adc_q[0].gap - 1;
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_ohms_q.size() == 0) begin
          $error("unexpected reading on channel %0d", out_channel_o);
          err_cnt++;
        end else begin
          exp_r = expected_ohms_q.pop_front();
          if (out_channel_o !== exp_r.ch) begin
            $error("out_channel: expected %0d, got %0d", exp_r.ch, out_channel_o);
            err_cnt++;
          end
          if (resistance_ohms_o !== exp_r.ohms) begin
            $error("resistance_ohms: expected %0d, got %0d", exp_r.ohms, resistance_ohms_o);
            err_cnt++;
          end
          if (open_circuit_o !== exp_r.open_circuit) begin
            $error("open_circuit: expected %0d, got %0d", exp_r.open_circuit, open_circuit_o);
            err_cnt++;
          end
          if (saturated_o !== exp_r.saturated) begin
            $error("saturated: expected %0d, got %0d", exp_r.saturated, saturated_o);
            err_cnt++;
          end
        end
        if (rx_calm_left == 0) begin
          rx_calm = ($urandom_range(0, 3) == 0);
          rx_calm_left = $urandom_range(10, 40);
        end else begin
          rx_calm_left--;
        end
        rx_wait = draw_gap(rx_calm);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** multichannel_average_divider_ohms: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [OHMS_W-1:0]   ohms_set [8];
    logic [SUPPLY_W-1:0] supply_set [8];
    ohms_set = '{20'd1, 20'd1000000, 20'hFFFFF, 20'd0, 20'd4700, 20'd0, 20'd220, 20'd0};
    supply_set = '{13'd1, 13'd5000, 13'h1FFF, 13'd0, 13'd3300, 13'd0, 13'd5000, 13'd0};
    ohms_set[5] = OHMS_W'($urandom_range(1, 1000000));
    ohms_set[7] = OHMS_W'($urandom_range(1, 1000000));
    supply_set[5] = SUPPLY_W'($urandom_range(1, 5000));
    supply_set[7] = SUPPLY_W'($urandom_range(1, 5000));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty window, single full-scale sample, full window, low sum
    @(negedge clk_i);
    push_item(ACT_MEASURE, 0, 0, 1'b0);
    push_item(ACT_MEASURE, CH_N - 1, 4095, 1'b0);
    repeat (WIN_N - 1) push_item(ACT_PRIME, 2, 4095, 1'b0);
    push_item(ACT_MEASURE, 2, 4095, 1'b0);
    push_item(ACT_MEASURE, 5, 20, 1'b0);
    push_item(ACT_MEASURE, 5, 0, 1'b0);
    wait_drained();

    // largest resistor: clamp just above the open threshold, open just below
    write_reg(REG_FIXED_OHMS, 20'hFFFFF);
    write_reg(REG_SUPPLY_MV, 20'd5000);
    @(negedge clk_i);
    push_item(ACT_MEASURE, 3, 14, 1'b0);
    push_item(ACT_MEASURE, 4, 13, 1'b0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_FIXED_OHMS, ohms_set[p]);
      // upper data bits are junk for the supply register
      write_reg(REG_SUPPLY_MV, {7'($urandom), supply_set[p]});
      @(negedge clk_i);
      run_random_phase(150);
      wait_drained();
    end

    if (err_cnt == 0 && expected_ohms_q.size() == 0) begin
      $display("** multichannel_average_divider_ohms: PASSED **");
    end else begin
      $display("** multichannel_average_divider_ohms: FAILED **");
    end
    $finish;
  end

endmodule
